// File: rtl/core/unicode_byte_stream_decoder_core_defines.svh
// Assertion macros shared by the Unicode byte stream decoder RTL.
// Standalone header; the modules that assert include it by bare file name.
`ifndef UNICODE_BYTE_STREAM_DECODER_CORE_DEFINES_SVH
`define UNICODE_BYTE_STREAM_DECODER_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define UBSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ubsd assertion failed");

// Antecedent implies consequent in the following cycle.
`define UBSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ubsd assertion failed");

`endif

// File: rtl/core/ubsd_pkg.sv
// Shared types and codes for the Unicode byte stream decoder.
// No dependencies; used by ubsd_decode and the top level.
package ubsd_pkg;

    localparam logic [2:0] MODE_UTF8    = 3'd0;
    localparam logic [2:0] MODE_UTF16LE = 3'd1;
    localparam logic [2:0] MODE_UTF16BE = 3'd2;
    localparam logic [2:0] MODE_UTF32LE = 3'd3;
    localparam logic [2:0] MODE_UTF32BE = 3'd4;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_BYTE    = 3'd1;
    localparam logic [2:0] ERR_RANGE       = 3'd2;
    localparam logic [2:0] ERR_SURROGATE   = 3'd3;
    localparam logic [2:0] ERR_LONE_LOW    = 3'd4;
    localparam logic [2:0] ERR_MISSING_LOW = 3'd5;
    localparam logic [2:0] ERR_LOCKED      = 3'd6;

    // UTF-8 sequence positions.
    localparam logic [2:0] PH_LEAD     = 3'd0;
    localparam logic [2:0] PH_2B_LAST  = 3'd1;
    localparam logic [2:0] PH_3B_MID   = 3'd2;
    localparam logic [2:0] PH_3B_LAST  = 3'd3;
    localparam logic [2:0] PH_4B_MID1  = 3'd4;
    localparam logic [2:0] PH_4B_MID2  = 3'd5;
    localparam logic [2:0] PH_4B_LAST  = 3'd6;

    // UTF-16 and UTF-32 byte positions.
    localparam logic [2:0] PH_BYTE0 = 3'd0;
    localparam logic [2:0] PH_BYTE1 = 3'd1;
    localparam logic [2:0] PH_BYTE2 = 3'd2;
    localparam logic [2:0] PH_BYTE3 = 3'd3;

    localparam logic [20:0] CP_MAX = 21'h10FFFF;

    typedef struct packed {
        logic [2:0]  phase;
        logic [23:0] partial;
        logic        locked;
    } dec_state_t;

    typedef struct packed {
        logic        emit;
        logic [20:0] code_point;
        logic        is_error;
        logic [2:0]  error_kind;
    } dec_result_t;

    localparam dec_state_t START_STATE = '{phase: 3'd0, partial: 24'd0, locked: 1'b0};

endpackage

// File: rtl/core/ubsd_decode.sv
// Single-byte decode step: next decoder state and optional result for one byte.
// Depends on ubsd_pkg.
module ubsd_decode (
    input  logic [2:0]             format_mode,
    input  ubsd_pkg::dec_state_t   state_cur,
    input  logic [7:0]             in_byte,
    input  logic                   restart,
    output ubsd_pkg::dec_state_t   state_next,
    output ubsd_pkg::dec_result_t  result
);

    ubsd_pkg::dec_state_t st;
    logic        big;
    logic        cont;
    logic [15:0] unit;
    logic [23:0] v8;
    logic [31:0] v32;
    logic [2:0]  kind;
    logic        done;
    logic [20:0] cp;
    logic [2:0]  phase_n;
    logic [23:0] part_n;

    assign st   = restart ? ubsd_pkg::START_STATE : state_cur;
    assign big  = (format_mode == ubsd_pkg::MODE_UTF16BE) ||
                  (format_mode == ubsd_pkg::MODE_UTF32BE);
    assign cont = in_byte inside {[8'h80:8'hBF]};
    assign unit = big ? {st.partial[7:0], in_byte} : {in_byte, st.partial[7:0]};
    assign v8   = st.partial | {18'd0, in_byte[5:0]};
    assign v32  = big ? {st.partial, in_byte} : {in_byte, st.partial};

    always_comb begin
        kind    = ubsd_pkg::ERR_NONE;
        done    = 1'b0;
        cp      = '0;
        phase_n = st.phase;
        part_n  = st.partial;
        case (format_mode)
            ubsd_pkg::MODE_UTF8: begin
                case (st.phase)
                    ubsd_pkg::PH_LEAD: begin
                        if (in_byte inside {[8'h00:8'h7F]}) begin
                            cp   = {13'd0, in_byte};
                            done = 1'b1;
                        end else if (in_byte inside {[8'hC2:8'hDF]}) begin
                            part_n  = {13'd0, in_byte[4:0], 6'd0};
                            phase_n = ubsd_pkg::PH_2B_LAST;
                        end else if (in_byte inside {[8'hE0:8'hEF]}) begin
                            part_n  = {8'd0, in_byte[3:0], 12'd0};
                            phase_n = ubsd_pkg::PH_3B_MID;
                        end else if (in_byte inside {[8'hF0:8'hF4]}) begin
                            part_n  = {3'd0, in_byte[2:0], 18'd0};
                            phase_n = ubsd_pkg::PH_4B_MID1;
                        end else begin
                            kind = ubsd_pkg::ERR_BAD_BYTE;
                        end
                    end
                    ubsd_pkg::PH_2B_LAST: begin
                        if (!cont) begin
                            kind = ubsd_pkg::ERR_BAD_BYTE;
                        end else begin
                            cp   = v8[20:0];
                            done = 1'b1;
                        end
                    end
                    ubsd_pkg::PH_3B_MID: begin
                        if (!cont) begin
                            kind = ubsd_pkg::ERR_BAD_BYTE;
                        end else begin
                            part_n  = st.partial | {12'd0, in_byte[5:0], 6'd0};
                            phase_n = ubsd_pkg::PH_3B_LAST;
                        end
                    end
                    ubsd_pkg::PH_3B_LAST: begin
                        if (!cont) begin
                            kind = ubsd_pkg::ERR_BAD_BYTE;
                        end else if (v8 < 24'h000800) begin
                            kind = ubsd_pkg::ERR_RANGE;
                        end else if (v8 inside {[24'h00D800:24'h00DFFF]}) begin
                            kind = ubsd_pkg::ERR_SURROGATE;
                        end else begin
                            cp   = v8[20:0];
                            done = 1'b1;
                        end
                    end
                    ubsd_pkg::PH_4B_MID1: begin
                        if (!cont) begin
                            kind = ubsd_pkg::ERR_BAD_BYTE;
                        end else begin
                            part_n  = st.partial | {6'd0, in_byte[5:0], 12'd0};
                            phase_n = ubsd_pkg::PH_4B_MID2;
                        end
                    end
                    ubsd_pkg::PH_4B_MID2: begin
                        if (!cont) begin
                            kind = ubsd_pkg::ERR_BAD_BYTE;
                        end else begin
                            part_n  = st.partial | {12'd0, in_byte[5:0], 6'd0};
                            phase_n = ubsd_pkg::PH_4B_LAST;
                        end
                    end
                    ubsd_pkg::PH_4B_LAST: begin
                        if (!cont) begin
                            kind = ubsd_pkg::ERR_BAD_BYTE;
                        end else if (v8 < 24'h010000 || v8 >= 24'h110000) begin
                            kind = ubsd_pkg::ERR_RANGE;
                        end else begin
                            cp   = v8[20:0];
                            done = 1'b1;
                        end
                    end
                    default: begin
                        kind = ubsd_pkg::ERR_BAD_BYTE;
                    end
                endcase
            end
            ubsd_pkg::MODE_UTF16LE, ubsd_pkg::MODE_UTF16BE: begin
                case (st.phase)
                    ubsd_pkg::PH_BYTE0, ubsd_pkg::PH_BYTE2: begin
                        part_n  = {st.partial[23:8], in_byte};
                        phase_n = st.phase + 3'd1;
                    end
                    ubsd_pkg::PH_BYTE1: begin
                        if (unit inside {[16'hD800:16'hDBFF]}) begin
                            part_n  = {unit, 8'd0};
                            phase_n = ubsd_pkg::PH_BYTE2;
                        end else if (unit inside {[16'hDC00:16'hDFFF]}) begin
                            kind = ubsd_pkg::ERR_LONE_LOW;
                        end else begin
                            cp   = {5'd0, unit};
                            done = 1'b1;
                        end
                    end
                    ubsd_pkg::PH_BYTE3: begin
                        if (!(unit inside {[16'hDC00:16'hDFFF]})) begin
                            kind = ubsd_pkg::ERR_MISSING_LOW;
                        end else begin
                            cp   = {1'b0, st.partial[17:8], unit[9:0]} + 21'h010000;
                            done = 1'b1;
                        end
                    end
                    default: begin
                        kind = ubsd_pkg::ERR_BAD_BYTE;
                    end
                endcase
            end
            ubsd_pkg::MODE_UTF32LE, ubsd_pkg::MODE_UTF32BE: begin
                case (st.phase)
                    ubsd_pkg::PH_BYTE0, ubsd_pkg::PH_BYTE1, ubsd_pkg::PH_BYTE2: begin
                        phase_n = st.phase + 3'd1;
                        if (big) begin
                            part_n = {st.partial[15:0], in_byte};
                        end else if (st.phase == ubsd_pkg::PH_BYTE0) begin
                            part_n = st.partial | {16'd0, in_byte};
                        end else if (st.phase == ubsd_pkg::PH_BYTE1) begin
                            part_n = st.partial | {8'd0, in_byte, 8'd0};
                        end else begin
                            part_n = st.partial | {in_byte, 16'd0};
                        end
                    end
                    ubsd_pkg::PH_BYTE3: begin
                        if (v32 >= 32'h00110000) begin
                            kind = ubsd_pkg::ERR_RANGE;
                        end else if (v32 inside {[32'h0000D800:32'h0000DFFF]}) begin
                            kind = ubsd_pkg::ERR_SURROGATE;
                        end else begin
                            cp   = v32[20:0];
                            done = 1'b1;
                        end
                    end
                    default: begin
                        kind = ubsd_pkg::ERR_BAD_BYTE;
                    end
                endcase
            end
            default: begin
                kind = ubsd_pkg::ERR_BAD_BYTE;
            end
        endcase
    end

    always_comb begin
        if (st.locked) begin
            state_next = st;
            result     = '{emit: 1'b1, code_point: 21'd0, is_error: 1'b1,
                           error_kind: ubsd_pkg::ERR_LOCKED};
        end else if (kind != ubsd_pkg::ERR_NONE) begin
            state_next = '{phase: 3'd0, partial: 24'd0, locked: 1'b1};
            result     = '{emit: 1'b1, code_point: 21'd0, is_error: 1'b1,
                           error_kind: kind};
        end else if (done) begin
            state_next = ubsd_pkg::START_STATE;
            result     = '{emit: 1'b1, code_point: cp, is_error: 1'b0,
                           error_kind: ubsd_pkg::ERR_NONE};
        end else begin
            state_next = '{phase: phase_n, partial: part_n, locked: st.locked};
            result     = '{emit: 1'b0, code_point: 21'd0, is_error: 1'b0,
                           error_kind: ubsd_pkg::ERR_NONE};
        end
    end

endmodule

// File: rtl/core/unicode_byte_stream_decoder_core.sv
// Top level of the Unicode byte stream decoder: input register, decode step, result register.
// Depends on ubsd_pkg, ubsd_decode and unicode_byte_stream_decoder_core_defines.svh.
//
//   Channel   Direction  Contents
//   s_*       in         one encoded byte per beat, restart flag in tuser
//   m_*       out        code point in tdata, error flag and kind in tuser
//   cfg_*     in         format mode write, restarts the decoder
//
// One byte is accepted every cycle while results drain; an accepted byte waits in the input register
// and is then decoded into the result register, which is loaded only when the decode step emits a result.
// The decode state updates in the same cycle a byte leaves the input register.
// Synchronous active-low reset selects UTF-8, clears the lock and empties both registers.
// A stalled m_tready holds the result and stops the input register once it is full.
`include "unicode_byte_stream_decoder_core_defines.svh"

module unicode_byte_stream_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [3:0]  m_tuser    // [0] is_error, [3:1] error_kind
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_restart_reg;
    logic [2:0]            mode_reg;
    ubsd_pkg::dec_state_t  state_reg;
    ubsd_pkg::dec_state_t  state_next;
    ubsd_pkg::dec_result_t result;
    logic                  m_valid_reg;
    logic [20:0]           out_cp_reg;
    logic                  out_err_reg;
    logic [2:0]            out_kind_reg;
    logic                  advance;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ubsd_decode u_decode (
        .format_mode (mode_reg),
        .state_cur   (state_reg),
        .in_byte     (in_byte_reg),
        .restart     (in_restart_reg),
        .state_next  (state_next),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            mode_reg     <= ubsd_pkg::MODE_UTF8;
            state_reg    <= ubsd_pkg::START_STATE;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= result.emit;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                mode_reg  <= cfg_wdata;
                state_reg <= ubsd_pkg::START_STATE;
            end else if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser[0];
        end
        if (advance && result.emit) begin
            out_cp_reg   <= result.code_point;
            out_err_reg  <= result.is_error;
            out_kind_reg <= result.error_kind;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, out_cp_reg};
    assign m_tuser  = {out_kind_reg, out_err_reg};

    `UBSD_ASSERT_IMPL(a_err_zero_cp, aclk, aresetn,
        m_valid_reg && out_err_reg,
        out_cp_reg == 21'd0 && out_kind_reg != ubsd_pkg::ERR_NONE)
    `UBSD_ASSERT_IMPL(a_ok_in_range, aclk, aresetn,
        m_valid_reg && !out_err_reg,
        out_kind_reg == ubsd_pkg::ERR_NONE && out_cp_reg <= ubsd_pkg::CP_MAX)
    `UBSD_ASSERT_NEXT(a_err_locks, aclk, aresetn,
        advance && result.emit && result.is_error && !cfg_we,
        state_reg.locked)
    `UBSD_ASSERT_IMPL(a_locked_clean, aclk, aresetn,
        state_reg.locked,
        state_reg.phase == 3'd0 && state_reg.partial == 24'd0)
    `UBSD_ASSERT_IMPL(a_phase_range, aclk, aresetn,
        1'b1,
        state_reg.phase != 3'd7)

endmodule
